/* rtl/lfx_pkg.sv */
// Package: shared constants, result type and checksum helpers for the frame receiver.
`timescale 1ns / 1ps

package lfx_pkg;

  localparam int unsigned MAX_FRAME   = 63;
  localparam int unsigned COUNT_W     = 8;
  localparam logic [7:0]  LINE_FEED   = 8'h0A;
  localparam logic [7:0]  SEPARATOR   = 8'h23;
  localparam logic [7:0]  MIN_CHECKED = 8'd4;
  localparam logic [7:0]  HEX_BASE    = 8'd16;
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(MAX_FRAME - 1);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT     = 2'd1,
    ST_NO_SEP    = 2'd2,
    ST_MISMATCH  = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               out_valid;
    logic               frame_done;
    frame_status_t      frame_status;
    logic [COUNT_W-1:0] frame_length;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // {digit valid, digit value}
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    hex_value = 5'b0_0000;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      hex_value = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      hex_value = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      hex_value = {1'b1, d[3:0]};
    end
  endfunction

  // Two characters read as a base-16 number, compared against want.
  function automatic logic digits_match(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] want);
    logic [1:0] i;
    logic [7:0] sel;
    logic [7:0] val;
    logic [4:0] hv;
    logic       neg;
    logic       stop;
    i    = 2'd0;
    val  = 8'h00;
    neg  = 1'b0;
    stop = 1'b0;
    if (is_space(c0)) begin
      i = 2'd1;
      if (is_space(c1)) i = 2'd2;
    end
    sel = (i == 2'd0) ? c0 : c1;
    if (i != 2'd2 && (sel == 8'h2B || sel == 8'h2D)) begin
      neg = (sel == 8'h2D);
      i = i + 2'd1;
    end
    for (int k = 0; k < 2; k++) begin
      sel = (i == 2'd0) ? c0 : c1;
      if (!stop && i == 2'(k)) begin
        hv = hex_value(sel);
        if (!hv[4]) begin
          stop = 1'b1;
        end else begin
          val = 8'(val * HEX_BASE) | {4'h0, hv[3:0]};
          i = i + 2'd1;
        end
      end
    end
    digits_match = !(neg && val != 8'h00) && (val == want);
  endfunction

endpackage

/* rtl/lfx_input_reg.sv */
// Input register: holds one received beat until the frame logic takes it.
`timescale 1ns / 1ps

module lfx_input_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign rx_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx_ready) begin
      held_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_ready && rx_valid) begin
      held_byte <= rx_byte;
    end
  end

endmodule

/* rtl/lfx_frame_core.sv */
// Frame logic: byte count, running xor, tail window and end-of-frame status.
`timescale 1ns / 1ps

module lfx_frame_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         check_enable,
  input  logic         go,
  input  logic [7:0]   in_byte,
  output logic         emit,
  output lfx_pkg::res_t res
);
  import lfx_pkg::*;

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]         running_xor, running_xor_next;
  logic [7:0]         tail_window [3];
  logic [7:0]         tail_window_next [3];
  logic               frame_end;
  logic               is_lf;
  logic [COUNT_W-1:0] count_inc;
  logic [7:0]         xor_upd;

  assign is_lf     = (in_byte == LINE_FEED);
  assign count_inc = byte_count + COUNT_W'(1);

  always_comb begin
    res                 = '0;
    res.frame_status    = ST_OK;
    frame_end           = 1'b0;
    byte_count_next     = byte_count;
    running_xor_next    = running_xor;
    tail_window_next[0] = tail_window[0];
    tail_window_next[1] = tail_window[1];
    tail_window_next[2] = tail_window[2];
    xor_upd             = running_xor;

    if (is_lf) begin
      frame_end = (byte_count != '0);
    end else begin
      if (check_enable) begin
        if (byte_count >= COUNT_W'(3)) begin
          res.out_byte  = tail_window[0];
          res.out_valid = 1'b1;
          xor_upd       = running_xor ^ tail_window[0];
        end
      end else begin
        res.out_byte  = in_byte;
        res.out_valid = 1'b1;
        xor_upd       = running_xor ^ in_byte;
      end
      tail_window_next[0] = tail_window[1];
      tail_window_next[1] = tail_window[2];
      tail_window_next[2] = in_byte;
      byte_count_next     = count_inc;
      running_xor_next    = xor_upd;
      frame_end           = (count_inc >= FULL_COUNT);
    end

    if (frame_end) begin
      res.frame_done = 1'b1;
      if (check_enable) begin
        res.frame_length = (byte_count_next >= COUNT_W'(3)) ?
                           byte_count_next - COUNT_W'(3) : '0;
        if (byte_count_next < COUNT_W'(MIN_CHECKED)) begin
          res.frame_status = ST_SHORT;
        end else if (tail_window_next[0] != SEPARATOR) begin
          res.frame_status = ST_NO_SEP;
        end else if (!digits_match(tail_window_next[1], tail_window_next[2],
                                   running_xor_next)) begin
          res.frame_status = ST_MISMATCH;
        end
      end else begin
        res.frame_length = byte_count_next;
      end
      byte_count_next     = '0;
      running_xor_next    = 8'h00;
      tail_window_next[0] = 8'h00;
      tail_window_next[1] = 8'h00;
      tail_window_next[2] = 8'h00;
    end
  end

  assign emit = go && (res.out_valid || res.frame_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      running_xor    <= 8'h00;
      tail_window[0] <= 8'h00;
      tail_window[1] <= 8'h00;
      tail_window[2] <= 8'h00;
    end else if (go) begin
      byte_count     <= byte_count_next;
      running_xor    <= running_xor_next;
      tail_window[0] <= tail_window_next[0];
      tail_window[1] <= tail_window_next[1];
      tail_window[2] <= tail_window_next[2];
    end
  end

endmodule

/* rtl/lfx_output_reg.sv */
// Output register: holds one result beat until the consumer takes it.
`timescale 1ns / 1ps

module lfx_output_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  lfx_pkg::res_t res_in,
  output logic          free,
  output logic          res_valid,
  input  logic          res_ready,
  output lfx_pkg::res_t res_q
);
  import lfx_pkg::*;

  assign free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (free) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

/* rtl/lf_frame_xor_check_receiver.sv */
// Top level: line-feed framed byte receiver with optional '#XX' xor checksum.
`timescale 1ns / 1ps
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  rx       | rx_valid / rx_ready  | rx_byte
//  result   | res_valid/res_ready  | out_byte out_valid frame_done frame_status
//           |                      | frame_length
//  config   | cfg_write            | cfg_data (check_enable)
//
//  One beat per cycle sustained while res_ready stays high; a beat that yields a
//  result passes from the input register via the frame logic to the result register.
//  Beats that yield no result (an empty line feed, the first three bytes of a
//  checked frame) update state only and never occupy the result register.
//  rst is synchronous; it clears the frame state and sets check_enable to 1.
//  A stalled result holds in place; the input register can still take one more beat.

module lf_frame_xor_check_receiver (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_ready,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       frame_done,
  output logic [1:0] frame_status,
  output logic [lfx_pkg::COUNT_W-1:0] frame_length,
  input  logic       cfg_write,
  input  logic       cfg_data
);
  import lfx_pkg::*;

  logic       check_enable;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       out_free;
  logic       go;
  logic       emit;
  res_t       core_res;
  res_t       res_q;

  // Single config register; write it only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable <= 1'b1;
    end else if (cfg_write) begin
      check_enable <= cfg_data;
    end
  end

  // Advance the held beat whenever the result register can take its outcome.
  assign go = held_valid && out_free;

  lfx_input_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .take       (go),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  lfx_frame_core u_core (
    .clk          (clk),
    .rst          (rst),
    .check_enable (check_enable),
    .go           (go),
    .in_byte      (held_byte),
    .emit         (emit),
    .res          (core_res)
  );

  lfx_output_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .res_in    (core_res),
    .free      (out_free),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_q     (res_q)
  );

  assign out_byte     = res_q.out_byte;
  assign out_valid    = res_q.out_valid;
  assign frame_done   = res_q.frame_done;
  assign frame_status = res_q.frame_status;
  assign frame_length = res_q.frame_length;

endmodule
